/* rtl/mrle_pkg.sv */
// shared types and constants of the mixed run-length pixel encoder
package mrle_pkg;

    localparam int PIXEL_W = 24;
    localparam int COUNT_W = 16;

    // configuration register index and channel width codes
    localparam logic [0:0] REG_CHANNEL_BYTES = 1'b0;
    localparam logic [1:0] CB_ONE = 2'd1;
    localparam logic [1:0] CB_TWO = 2'd2;

    localparam logic [PIXEL_W-1:0] MASK_ONE = 24'h0000FF;
    localparam logic [PIXEL_W-1:0] MASK_TWO = 24'h00FFFF;
    localparam logic [PIXEL_W-1:0] MASK_ALL = 24'hFFFFFF;

    // packet header codes
    localparam logic [7:0] HDR_LONG_RUN = 8'd128;
    localparam logic [7:0] HDR_RUN_BIAS = 8'd127;
    localparam logic [COUNT_W-1:0] SHORT_RUN_LIMIT = 16'd128;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic               end_of_line;
    } pix_item_t;

    typedef struct packed {
        logic               header_valid;
        logic [7:0]         header_byte;
        logic               count_valid;
        logic [COUNT_W-1:0] run_count;
        logic               first_pixel_valid;
        logic [PIXEL_W-1:0] first_pixel;
        logic               second_pixel_valid;
        logic [PIXEL_W-1:0] second_pixel;
        logic               last_result;
    } pkt_item_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_LIT,
        JOB_RUN
    } job_kind_t;

    // one packet to send: literal from the pixel store, or a repeat run
    typedef struct packed {
        job_kind_t          kind;
        logic [COUNT_W-1:0] len;
        logic [PIXEL_W-1:0] pix;
    } job_t;

    typedef struct packed {
        job_t first;
        job_t second;
    } job_pair_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT_READ,
        ST_LIT_SEND,
        ST_RUN_SEND
    } emit_state_t;

endpackage

/* rtl/mrle_ram.sv */
// generic single-write, single-read ram with registered read data
module mrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/mrle_tracker.sv */
// run tracker: pending count, repeat mode and packet decisions for each pixel
module mrle_tracker #(
    parameter int LITERAL_MAX = 128,
    parameter int RUN_MAX     = 65535
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic [mrle_pkg::PIXEL_W-1:0]         pixel,
    input  logic                                 eol,
    output mrle_pkg::job_pair_t                  jobs,
    output logic                                 wr_en,
    output logic [$clog2(LITERAL_MAX)-1:0]       wr_idx,
    output logic [mrle_pkg::PIXEL_W-1:0]         wr_data
);

    localparam int IW = $clog2(LITERAL_MAX);
    localparam int CNT_W = mrle_pkg::COUNT_W;

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        rep_reg, rep_next;
    logic [mrle_pkg::PIXEL_W-1:0] last_pix_reg;
    logic [CNT_W:0]              cnt_inc;
    logic                        same;
    mrle_pkg::job_t              job_main;
    mrle_pkg::job_t              job_eol;

    assign same    = (pixel == last_pix_reg);
    assign cnt_inc = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign wr_data = pixel;

    // decide the packets caused by this pixel and the new run state
    always_comb
    begin
        cnt_next = cnt_reg;
        rep_next = rep_reg;
        wr_en    = 1'b0;
        wr_idx   = '0;
        job_main = '{kind: mrle_pkg::JOB_NONE, len: '0, pix: '0};
        job_eol  = '{kind: mrle_pkg::JOB_NONE, len: '0, pix: '0};
        jobs     = '{first: job_main, second: job_eol};

        if (take)
        begin
            priority if (cnt_reg == '0)
            begin
                // start of a new packet
                wr_en    = 1'b1;
                wr_idx   = '0;
                cnt_next = CNT_W'(1);
                rep_next = 1'b0;
            end
            else if (cnt_reg == CNT_W'(1))
            begin
                if (same)
                begin
                    rep_next = 1'b1;
                    cnt_next = CNT_W'(2);
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_idx   = IW'(1);
                    cnt_next = CNT_W'(2);
                    rep_next = 1'b0;
                    if (2 >= LITERAL_MAX)
                    begin
                        job_main = '{kind: mrle_pkg::JOB_LIT, len: CNT_W'(2), pix: '0};
                        cnt_next = '0;
                    end
                end
            end
            else if (!rep_reg && same)
            begin
                // literal meets two equal pixels: flush all but the last, repeat of two
                job_main = '{kind: mrle_pkg::JOB_LIT, len: cnt_reg - CNT_W'(1), pix: '0};
                cnt_next = CNT_W'(2);
                rep_next = 1'b1;
            end
            else if (rep_reg && !same)
            begin
                // repeat run broken by a new pixel
                job_main = '{kind: mrle_pkg::JOB_RUN, len: cnt_reg, pix: last_pix_reg};
                wr_en    = 1'b1;
                wr_idx   = '0;
                cnt_next = CNT_W'(1);
                rep_next = 1'b0;
            end
            else if (!rep_reg)
            begin
                // literal growth
                wr_en    = 1'b1;
                wr_idx   = cnt_reg[IW-1:0];
                cnt_next = cnt_inc[CNT_W-1:0];
                if (cnt_inc >= (CNT_W+1)'(LITERAL_MAX))
                begin
                    job_main = '{kind: mrle_pkg::JOB_LIT, len: cnt_inc[CNT_W-1:0], pix: '0};
                    cnt_next = '0;
                    rep_next = 1'b0;
                end
            end
            else
            begin
                // repeat growth
                cnt_next = cnt_inc[CNT_W-1:0];
                if (cnt_inc >= (CNT_W+1)'(RUN_MAX))
                begin
                    job_main = '{kind: mrle_pkg::JOB_RUN, len: cnt_inc[CNT_W-1:0],
                                 pix: last_pix_reg};
                    cnt_next = '0;
                    rep_next = 1'b0;
                end
            end

            // end of line flushes whatever is pending
            if (eol)
            begin
                if (cnt_next != '0)
                begin
                    if (cnt_next == CNT_W'(1) || !rep_next)
                    begin
                        job_eol = '{kind: mrle_pkg::JOB_LIT, len: cnt_next, pix: '0};
                    end
                    else
                    begin
                        job_eol = '{kind: mrle_pkg::JOB_RUN, len: cnt_next, pix: pixel};
                    end
                end
                cnt_next = '0;
                rep_next = 1'b0;
            end

            if (job_main.kind == mrle_pkg::JOB_NONE)
            begin
                jobs = '{first: job_eol, second: job_main};
            end
            else
            begin
                jobs = '{first: job_main, second: job_eol};
            end
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rep_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rep_reg <= rep_next;
        end
    end

    // most recent pixel, the compare target in both modes
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_pix_reg <= pixel;
        end
    end

    a_rep_min_two: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg |-> (cnt_reg >= CNT_W'(2)))
        else $error("repeat mode with fewer than two pixels");

    a_lit_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        !rep_reg |-> ({1'b0, cnt_reg} < (CNT_W+1)'(LITERAL_MAX)))
        else $error("literal run not flushed at its limit");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && eol) |=> (cnt_reg == '0 && !rep_reg))
        else $error("end of line left a pending run");

endmodule

/* rtl/mrle_emit.sv */
// packet sequencer: reads the pixel store and fills the result register
module mrle_emit #(
    parameter int LITERAL_MAX = 128,
    parameter int PW          = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mrle_pkg::job_pair_t           jobs,
    output logic                          busy,
    output logic                          rd_en,
    output logic [PW-1:0]                 rd_addr,
    input  logic [mrle_pkg::PIXEL_W-1:0]  rd_even,
    input  logic [mrle_pkg::PIXEL_W-1:0]  rd_odd,
    output logic                          pkt_valid,
    input  logic                          pkt_stall,
    output mrle_pkg::pkt_item_t           pkt_data
);

    localparam int CW = $clog2(LITERAL_MAX + 1);

    mrle_pkg::emit_state_t state_reg, state_next;
    logic                  sel_reg, sel_next;
    mrle_pkg::job_pair_t   jobs_reg, jobs_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic                  head_reg, head_next;
    logic                  pkt_valid_reg, pkt_valid_next;
    mrle_pkg::pkt_item_t   pkt_data_reg, pkt_data_next;

    mrle_pkg::job_t        cur;
    mrle_pkg::job_t        launch_job;
    logic                  launch_en;
    logic                  done;
    logic                  last_job;
    logic                  slot_free;
    logic                  load;
    mrle_pkg::pkt_item_t   item;

    assign cur       = sel_reg ? jobs_reg.second : jobs_reg.first;
    assign last_job  = sel_reg || (jobs_reg.second.kind == mrle_pkg::JOB_NONE);
    assign slot_free = !pkt_valid_reg || !pkt_stall;
    assign busy      = (state_reg != mrle_pkg::ST_IDLE);
    assign pkt_valid = pkt_valid_reg;
    assign pkt_data  = pkt_data_reg;

    // sequencer next state and result assembly
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        jobs_next  = jobs_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        head_next  = head_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        load       = 1'b0;
        done       = 1'b0;
        launch_en  = 1'b0;
        launch_job = jobs.first;
        item       = '0;

        unique case (state_reg)
            mrle_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    jobs_next  = jobs;
                    sel_next   = 1'b0;
                    launch_en  = 1'b1;
                    launch_job = jobs.first;
                end
            end
            mrle_pkg::ST_LIT_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = mrle_pkg::ST_LIT_SEND;
            end
            mrle_pkg::ST_LIT_SEND:
            begin
                if (slot_free)
                begin
                    load                    = 1'b1;
                    item.header_valid       = head_reg;
                    item.header_byte        = head_reg ? 8'(rem_reg - CW'(1)) : 8'd0;
                    item.first_pixel_valid  = 1'b1;
                    item.first_pixel        = rd_even;
                    item.second_pixel_valid = (rem_reg >= CW'(2));
                    item.second_pixel       = (rem_reg >= CW'(2)) ? rd_odd : '0;
                    item.last_result        = (rem_reg <= CW'(2)) && last_job;
                    ptr_next                = ptr_reg + PW'(1);
                    rem_next                = rem_reg - CW'(2);
                    head_next               = 1'b0;
                    if (rem_reg <= CW'(2))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        // fetch the next pair while this one is sent
                        rd_en   = 1'b1;
                        rd_addr = ptr_reg + PW'(1);
                    end
                end
            end
            mrle_pkg::ST_RUN_SEND:
            begin
                if (slot_free)
                begin
                    load              = 1'b1;
                    item.header_valid = 1'b1;
                    if (cur.len < mrle_pkg::SHORT_RUN_LIMIT)
                    begin
                        item.header_byte = cur.len[7:0] + mrle_pkg::HDR_RUN_BIAS;
                    end
                    else
                    begin
                        item.header_byte = mrle_pkg::HDR_LONG_RUN;
                        item.count_valid = 1'b1;
                        item.run_count   = cur.len;
                    end
                    item.first_pixel_valid = 1'b1;
                    item.first_pixel       = cur.pix;
                    item.last_result       = last_job;
                    done                   = 1'b1;
                end
            end
            default:
            begin
                state_next = mrle_pkg::ST_IDLE;
            end
        endcase

        // move on to the second packet or finish
        if (done)
        begin
            if (!last_job)
            begin
                sel_next   = 1'b1;
                launch_en  = 1'b1;
                launch_job = jobs_reg.second;
            end
            else
            begin
                state_next = mrle_pkg::ST_IDLE;
            end
        end

        // start a packet
        if (launch_en)
        begin
            unique case (launch_job.kind)
                mrle_pkg::JOB_LIT:
                begin
                    state_next = mrle_pkg::ST_LIT_READ;
                    ptr_next   = '0;
                    rem_next   = CW'(launch_job.len);
                    head_next  = 1'b1;
                end
                mrle_pkg::JOB_RUN:
                begin
                    state_next = mrle_pkg::ST_RUN_SEND;
                end
                default:
                begin
                    state_next = mrle_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        pkt_valid_next = pkt_valid_reg;
        pkt_data_next  = pkt_data_reg;
        if (load)
        begin
            pkt_valid_next = 1'b1;
            pkt_data_next  = item;
        end
        else if (!pkt_stall)
        begin
            pkt_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrle_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            jobs_reg      <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            head_reg      <= 1'b0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            jobs_reg      <= jobs_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            head_reg      <= head_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pkt_data_reg <= pkt_data_next;
    end

    a_lit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrle_pkg::ST_LIT_SEND) |-> (rem_reg != '0))
        else $error("literal packet with no pixels left");

    a_busy_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mrle_pkg::ST_IDLE) |-> (jobs_reg.first.kind != mrle_pkg::JOB_NONE))
        else $error("sequencer busy without a packet");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mrle_pkg::ST_IDLE && state_next == mrle_pkg::ST_IDLE)
        |-> (pkt_valid_next && pkt_data_next.last_result))
        else $error("item finished without a last result");

endmodule

/* rtl/mixed_rle_pixel_encoder_unit.sv */
// Mixed run-length pixel encoder: one scanline pixel per transfer in, literal and repeat
// packets out. Each output transfer carries an optional header, an optional 16-bit long-run
// count and up to two pixels. Pixels are masked to channel_bytes bytes (register at byte
// address 0; 1 = low byte, 2 = two bytes, 3 or 0 = all three). The tracker decides an accepted
// pixel's packets combinationally; the input is then stalled while they are sent: a repeat
// packet is one transfer, and a literal packet first reads the pixel store, then sends one
// pixel pair a cycle from the two banks of the store unless the output stalls. A pixel that
// closes no packet does not stall the input, and the result register lets the next pixel in
// while the last result still waits to be taken. No clearing pass is needed after reset.
module mixed_rle_pixel_encoder_unit #(
    parameter int LITERAL_MAX = 128,
    parameter int RUN_MAX     = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  mrle_pkg::pix_item_t pix_data,
    output logic                pkt_valid,
    input  logic                pkt_stall,
    output mrle_pkg::pkt_item_t pkt_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW         = $clog2(LITERAL_MAX);
    localparam int HOLD_DEPTH = (LITERAL_MAX + 1) / 2;
    localparam int PW         = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    logic [1:0]                   ch_reg;
    logic [mrle_pkg::PIXEL_W-1:0] mask;
    logic [mrle_pkg::PIXEL_W-1:0] pixel;
    logic                         take;
    logic                         busy;
    mrle_pkg::job_pair_t          jobs;
    logic                         wr_en;
    logic [IW-1:0]                wr_idx;
    logic [mrle_pkg::PIXEL_W-1:0] wr_data;
    logic [PW-1:0]                wr_pair;
    logic                         rd_en;
    logic [PW-1:0]                rd_addr;
    logic [mrle_pkg::PIXEL_W-1:0] rd_even;
    logic [mrle_pkg::PIXEL_W-1:0] rd_odd;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mrle_pkg::REG_CHANNEL_BYTES) ? {30'd0, ch_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= 2'd3;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == mrle_pkg::REG_CHANNEL_BYTES)
        begin
            ch_reg <= pwdata[1:0];
        end
    end

    // channel mask
    always_comb
    begin
        unique case (ch_reg)
            mrle_pkg::CB_ONE: mask = mrle_pkg::MASK_ONE;
            mrle_pkg::CB_TWO: mask = mrle_pkg::MASK_TWO;
            default:          mask = mrle_pkg::MASK_ALL;
        endcase
    end

    assign pixel     = pix_data.pixel_value & mask;
    assign take      = pix_valid && !busy;
    assign pix_stall = busy;

    mrle_tracker #(
        .LITERAL_MAX (LITERAL_MAX),
        .RUN_MAX     (RUN_MAX)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .pixel   (pixel),
        .eol     (pix_data.end_of_line),
        .jobs    (jobs),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    // pixel store: even and odd entries in separate banks, one pair read a cycle unless the output stalls
    assign wr_pair = PW'(wr_idx >> 1);

    mrle_ram #(
        .WIDTH (mrle_pkg::PIXEL_W),
        .DEPTH (HOLD_DEPTH)
    ) u_bank_even (
        .clk     (clk),
        .wr_en   (wr_en && !wr_idx[0]),
        .wr_addr (wr_pair),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_even)
    );

    mrle_ram #(
        .WIDTH (mrle_pkg::PIXEL_W),
        .DEPTH (HOLD_DEPTH)
    ) u_bank_odd (
        .clk     (clk),
        .wr_en   (wr_en && wr_idx[0]),
        .wr_addr (wr_pair),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_odd)
    );

    mrle_emit #(
        .LITERAL_MAX (LITERAL_MAX),
        .PW          (PW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (take),
        .jobs      (jobs),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_even   (rd_even),
        .rd_odd    (rd_odd),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_data  (pkt_data)
    );

endmodule
